// File: rtl/core/qsort_pkg.sv
// Shared types and constants of the quicksort sorter.
`default_nettype none

package qsort_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COUNT_W = 11;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WT,
    S_DONE,
    S_PIV_RD,
    S_PIV_WT,
    S_P_RD,
    S_P_CMP,
    S_P_SW,
    S_FIN_WR,
    S_SPLIT,
    S_POP,
    S_I_RDK,
    S_I_WTK,
    S_I_CHK,
    S_I_CMP
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/qsort_in_if.sv
// Request channel of the sorter: load and read requests.
`default_nettype none

interface qsort_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [qsort_pkg::VALUE_W-1:0] value;
  logic [qsort_pkg::INDEX_W-1:0] index;
  logic                          last;

  modport source (output valid, mode, value, index, last, input ready);
  modport sink   (input valid, mode, value, index, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/qsort_out_if.sv
// Result channel of the sorter: done, read data and out-of-range results.
`default_nettype none

interface qsort_out_if;
  logic                          valid;
  logic                          ready;
  logic [qsort_pkg::KIND_W-1:0]  kind;
  logic [qsort_pkg::VALUE_W-1:0] data;
  logic [qsort_pkg::COUNT_W-1:0] count;

  modport source (output valid, kind, data, count, input ready);
  modport sink   (input valid, kind, data, count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/quicksort_lomuto_sorter_top.sv
// Quicksort sorter top level: value store, range stack and sort sequencer.
//
// Usage: requests arrive on in_ch. A load request (mode 0) appends value to the
// store; loads beyond CAPACITY are dropped. A load with last set starts an
// in-place quicksort (Lomuto partition, rightmost pivot) and a done result
// carrying the count follows on out_ch. A read request (mode 1) returns the
// value at index, or an out-of-range result when index is not below the count.
// A load after a finished sort starts a new batch.
// A load without last gives no result. A read passes from S_IDLE through S_RD_WT,
// which sets the result register; no new request is taken before that result is set.
// A sort scans each element of a partition in S_P_RD and S_P_CMP, adding S_P_SW
// when it is swapped, plus S_PIV_RD, S_PIV_WT, S_FIN_WR and S_SPLIT per partition
// and S_POP per range taken from the stack; the scan work grows as N*log2(N) for
// random data and up to N*N for presorted or constant data. When the range stack
// is full, larger ranges are insertion sorted through S_I_RDK to S_I_CMP.
// A single result register sits on out_ch; a request is taken while a result
// waits only if that result is taken in the same cycle. While the receiver
// stalls, the held result stays and no new request is accepted.
// Reset clears the count, the sorted flag and the stack pointer; the store is
// not cleared, since only entries below the count are ever read.
`default_nettype none

module quicksort_lomuto_sorter_top #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  qsort_in_if.sink    in_ch,
  qsort_out_if.source out_ch
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned SPW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SIW  = $clog2(STACK_DEPTH);
  localparam int unsigned CMPW = (CW > qsort_pkg::INDEX_W) ? CW : qsort_pkg::INDEX_W;
  localparam int unsigned OW   = (CW > qsort_pkg::COUNT_W) ? CW : qsort_pkg::COUNT_W;

  // Value store and range stack.
  logic [qsort_pkg::VALUE_W-1:0] store_mem [CAPACITY];
  logic [AW-1:0]                 stack_lo_r [STACK_DEPTH];
  logic [AW-1:0]                 stack_hi_r [STACK_DEPTH];

  qsort_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           sorted_r, sorted_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [AW-1:0]                 lo_r, lo_nxt;
  logic [AW-1:0]                 hi_r, hi_nxt;
  logic [AW-1:0]                 k_r, k_nxt;
  logic [AW-1:0]                 slot_r, slot_nxt;
  logic [qsort_pkg::VALUE_W-1:0] pivot_r, pivot_nxt;
  logic                          small_ok_r, small_ok_nxt;
  logic [AW-1:0]                 ins_lo_r, ins_lo_nxt;
  logic [AW-1:0]                 ins_hi_r, ins_hi_nxt;
  logic [AW:0]                   ik_r, ik_nxt;
  logic [AW-1:0]                 im_r, im_nxt;
  logic [qsort_pkg::VALUE_W-1:0] iv_r, iv_nxt;
  logic                          range_r, range_nxt;
  logic [qsort_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [qsort_pkg::VALUE_W-1:0] out_data_r, out_data_nxt;
  logic [qsort_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  // Store port controls.
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [qsort_pkg::VALUE_W-1:0] mem_wdata;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr_a, rd_addr_b;
  logic [qsort_pkg::VALUE_W-1:0] rd_a_r, rd_b_r;

  logic push_en;

  // Helper values.
  logic                          in_accept;
  logic [CW-1:0]                 load_base, load_cnt;
  logic [CW-1:0]                 load_cnt_dec;
  logic [CMPW-1:0]               idx_ext;
  logic [OW-1:0]                 cnt_ext;
  logic [qsort_pkg::COUNT_W-1:0] cnt_out;
  logic [AW-1:0]                 left_n, right_n, p_inc, p_dec;
  logic [AW-1:0]                 big_lo, big_hi, small_lo, small_hi;
  logic                          take_left, big_ok, small_ok, stack_full;
  logic [SPW-1:0]                sp_dec;
  logic [SIW-1:0]                top_idx;

  assign in_ch.ready = (state_r == qsort_pkg::S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.data  = out_data_r;
  assign out_ch.count = out_count_r;

  assign load_base    = sorted_r ? '0 : cnt_r;
  assign load_cnt     = (load_base < CW'(CAPACITY)) ? load_base + CW'(1) : load_base;
  assign load_cnt_dec = load_cnt - CW'(1);
  assign idx_ext      = CMPW'(in_ch.index);
  assign cnt_ext      = OW'(cnt_r);
  assign cnt_out      = cnt_ext[qsort_pkg::COUNT_W-1:0];

  // The pivot has landed in slot; the larger side is pushed, the smaller worked on.
  assign left_n     = slot_r - lo_r;
  assign right_n    = hi_r - slot_r;
  assign p_inc      = slot_r + AW'(1);
  assign p_dec      = slot_r - AW'(1);
  assign take_left  = left_n >= right_n;
  assign big_lo     = take_left ? lo_r : p_inc;
  assign big_hi     = take_left ? p_dec : hi_r;
  assign small_lo   = take_left ? p_inc : lo_r;
  assign small_hi   = take_left ? hi_r : p_dec;
  assign big_ok     = take_left ? (left_n > AW'(1)) : (right_n > AW'(1));
  assign small_ok   = take_left ? (right_n > AW'(1)) : (left_n > AW'(1));
  assign stack_full = sp_r == SPW'(STACK_DEPTH);
  assign sp_dec     = sp_r - SPW'(1);
  assign top_idx    = sp_dec[SIW-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sorted_nxt    = sorted_r;
    sp_nxt        = sp_r;
    out_valid_nxt = out_valid_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    slot_nxt      = slot_r;
    pivot_nxt     = pivot_r;
    small_ok_nxt  = small_ok_r;
    ins_lo_nxt    = ins_lo_r;
    ins_hi_nxt    = ins_hi_r;
    ik_nxt        = ik_r;
    im_nxt        = im_r;
    iv_nxt        = iv_r;
    range_nxt     = range_r;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_count_nxt = out_count_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    rd_en         = 1'b0;
    rd_addr_a     = '0;
    rd_addr_b     = '0;
    push_en       = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      qsort_pkg::S_IDLE: begin
        if (in_accept) begin
          if (in_ch.mode == qsort_pkg::MODE_LOAD) begin
            sorted_nxt = 1'b0;
            cnt_nxt    = load_cnt;
            if (load_base < CW'(CAPACITY)) begin
              mem_we    = 1'b1;
              mem_waddr = load_base[AW-1:0];
              mem_wdata = in_ch.value;
            end
            if (in_ch.last) begin
              if (load_cnt < CW'(2)) begin
                state_nxt = qsort_pkg::S_DONE;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = load_cnt_dec[AW-1:0];
                state_nxt = qsort_pkg::S_PIV_RD;
              end
            end
          end else begin
            rd_en     = 1'b1;
            rd_addr_a = idx_ext[AW-1:0];
            range_nxt = !((idx_ext < CMPW'(cnt_r)) && (idx_ext < CMPW'(CAPACITY)));
            state_nxt = qsort_pkg::S_RD_WT;
          end
        end
      end
      qsort_pkg::S_RD_WT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = range_r ? qsort_pkg::KIND_RANGE : qsort_pkg::KIND_DATA;
        out_data_nxt  = range_r ? '0 : rd_a_r;
        out_count_nxt = cnt_out;
        state_nxt     = qsort_pkg::S_IDLE;
      end
      qsort_pkg::S_DONE: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = qsort_pkg::KIND_DONE;
        out_data_nxt  = '0;
        out_count_nxt = cnt_out;
        sorted_nxt    = 1'b1;
        state_nxt     = qsort_pkg::S_IDLE;
      end
      qsort_pkg::S_PIV_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = hi_r;
        state_nxt = qsort_pkg::S_PIV_WT;
      end
      qsort_pkg::S_PIV_WT: begin
        pivot_nxt = rd_a_r;
        k_nxt     = lo_r;
        slot_nxt  = lo_r;
        state_nxt = qsort_pkg::S_P_RD;
      end
      qsort_pkg::S_P_RD: begin
        rd_en = 1'b1;
        if (k_r == hi_r) begin
          // Scan finished: fetch the slot value that swaps with the pivot.
          rd_addr_a = slot_r;
          state_nxt = qsort_pkg::S_FIN_WR;
        end else begin
          rd_addr_a = k_r;
          rd_addr_b = slot_r;
          state_nxt = qsort_pkg::S_P_CMP;
        end
      end
      qsort_pkg::S_P_CMP: begin
        if ($signed(rd_a_r) < $signed(pivot_r)) begin
          mem_we    = 1'b1;
          mem_waddr = slot_r;
          mem_wdata = rd_a_r;
          state_nxt = qsort_pkg::S_P_SW;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = qsort_pkg::S_P_RD;
        end
      end
      qsort_pkg::S_P_SW: begin
        mem_we    = 1'b1;
        mem_waddr = k_r;
        mem_wdata = rd_b_r;
        k_nxt     = k_r + AW'(1);
        slot_nxt  = slot_r + AW'(1);
        state_nxt = qsort_pkg::S_P_RD;
      end
      qsort_pkg::S_FIN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = rd_a_r;
        state_nxt = qsort_pkg::S_SPLIT;
      end
      qsort_pkg::S_SPLIT: begin
        mem_we       = 1'b1;
        mem_waddr    = slot_r;
        mem_wdata    = pivot_r;
        lo_nxt       = small_lo;
        hi_nxt       = small_hi;
        small_ok_nxt = small_ok;
        if (big_ok && stack_full) begin
          ins_lo_nxt = big_lo;
          ins_hi_nxt = big_hi;
          ik_nxt     = {1'b0, big_lo} + (AW + 1)'(1);
          state_nxt  = qsort_pkg::S_I_RDK;
        end else begin
          if (big_ok) begin
            push_en = 1'b1;
            sp_nxt  = sp_r + SPW'(1);
          end
          state_nxt = small_ok ? qsort_pkg::S_PIV_RD : qsort_pkg::S_POP;
        end
      end
      qsort_pkg::S_POP: begin
        if (sp_r == '0) begin
          state_nxt = qsort_pkg::S_DONE;
        end else begin
          lo_nxt    = stack_lo_r[top_idx];
          hi_nxt    = stack_hi_r[top_idx];
          sp_nxt    = sp_dec;
          state_nxt = qsort_pkg::S_PIV_RD;
        end
      end
      qsort_pkg::S_I_RDK: begin
        if (ik_r > {1'b0, ins_hi_r}) begin
          state_nxt = small_ok_r ? qsort_pkg::S_PIV_RD : qsort_pkg::S_POP;
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = ik_r[AW-1:0];
          state_nxt = qsort_pkg::S_I_WTK;
        end
      end
      qsort_pkg::S_I_WTK: begin
        iv_nxt    = rd_a_r;
        im_nxt    = ik_r[AW-1:0];
        state_nxt = qsort_pkg::S_I_CHK;
      end
      qsort_pkg::S_I_CHK: begin
        if (im_r == ins_lo_r) begin
          mem_we    = 1'b1;
          mem_waddr = im_r;
          mem_wdata = iv_r;
          ik_nxt    = ik_r + (AW + 1)'(1);
          state_nxt = qsort_pkg::S_I_RDK;
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = im_r - AW'(1);
          state_nxt = qsort_pkg::S_I_CMP;
        end
      end
      qsort_pkg::S_I_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = im_r;
        if ($signed(iv_r) < $signed(rd_a_r)) begin
          mem_wdata = rd_a_r;
          im_nxt    = im_r - AW'(1);
          state_nxt = qsort_pkg::S_I_CHK;
        end else begin
          mem_wdata = iv_r;
          ik_nxt    = ik_r + (AW + 1)'(1);
          state_nxt = qsort_pkg::S_I_RDK;
        end
      end
      default: begin
        state_nxt = qsort_pkg::S_IDLE;
      end
    endcase
  end

  // Reads are never issued in a cycle that writes, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_r <= store_mem[rd_addr_a];
      rd_b_r <= store_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_lo_r[sp_r[SIW-1:0]] <= big_lo;
      stack_hi_r[sp_r[SIW-1:0]] <= big_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qsort_pkg::S_IDLE;
      cnt_r       <= '0;
      sorted_r    <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sorted_r    <= sorted_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    k_r         <= k_nxt;
    slot_r      <= slot_nxt;
    pivot_r     <= pivot_nxt;
    small_ok_r  <= small_ok_nxt;
    ins_lo_r    <= ins_lo_nxt;
    ins_hi_r    <= ins_hi_nxt;
    ik_r        <= ik_nxt;
    im_r        <= im_nxt;
    iv_r        <= iv_nxt;
    range_r     <= range_nxt;
    out_kind_r  <= out_kind_nxt;
    out_data_r  <= out_data_nxt;
    out_count_r <= out_count_nxt;
  end

`ifndef SYNTHESIS
  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!out_valid_r || out_ch.ready))
    else $error("request taken while the result register stays full");

  a_result_reg_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qsort_pkg::S_DONE || state_r == qsort_pkg::S_RD_WT) |-> !out_valid_r)
    else $error("result would overwrite a pending result");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("range stack pointer beyond depth");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count beyond capacity");
`endif

endmodule

`default_nettype wire
